FILE: design/mlrq_pkg.sv
// Shared codes, reset values and parameter defaults for the multilevel ready queue.
`timescale 1ns / 1ps
package mlrq_pkg;

  localparam int LEVEL_COUNT_DEF = 4;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;

  localparam int QUANTUM_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 2;
  localparam int OUT_LVL_W = 2;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THREE = 2'd3;

  localparam logic [QUANTUM_W-1:0] LIMIT_ONE_RST   = 16'd1;
  localparam logic [QUANTUM_W-1:0] LIMIT_TWO_RST   = 16'd2;
  localparam logic [QUANTUM_W-1:0] LIMIT_THREE_RST = 16'd4;

endpackage

FILE: design/mlrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: design/mlrq_front.sv
// Front end: config registers, level classification and a two-entry command queue.
`timescale 1ns / 1ps
module mlrq_front #(
  parameter int LEVEL_COUNT = mlrq_pkg::LEVEL_COUNT_DEF,
  parameter int ID_WIDTH    = mlrq_pkg::ID_WIDTH_DEF,
  localparam int LW         = $clog2(LEVEL_COUNT)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [ID_WIDTH-1:0]            in_thread_id,
  input  logic [mlrq_pkg::QUANTUM_W-1:0] in_quantum_used,
  input  logic                           cfg_valid,
  input  logic [mlrq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlrq_pkg::QUANTUM_W-1:0] cfg_data,
  output logic                           cmd_valid,
  input  logic                           cmd_pop,
  output logic                           cmd_op,
  output logic [ID_WIDTH-1:0]            cmd_tid,
  output logic [LW-1:0]                  cmd_level
);
  import mlrq_pkg::*;

  logic                 single_mode_r;
  logic [QUANTUM_W-1:0] lim1_r, lim2_r, lim3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_mode_r <= 1'b0;
      lim1_r        <= LIMIT_ONE_RST;
      lim2_r        <= LIMIT_TWO_RST;
      lim3_r        <= LIMIT_THREE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SINGLE_MODE: single_mode_r <= cfg_data[0];
        CFG_LIMIT_ONE:   lim1_r        <= cfg_data;
        CFG_LIMIT_TWO:   lim2_r        <= cfg_data;
        CFG_LIMIT_THREE: lim3_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // limits are tested in order; the first that holds wins
  logic [1:0]    raw_lvl;
  logic [LW-1:0] new_lvl;

  always_comb begin
    priority if (in_quantum_used <= lim1_r) raw_lvl = 2'd0;
    else if (in_quantum_used <= lim2_r)     raw_lvl = 2'd1;
    else if (in_quantum_used <= lim3_r)     raw_lvl = 2'd2;
    else                                    raw_lvl = 2'd3;
    if (single_mode_r) begin
      new_lvl = '0;
    end else if (int'(raw_lvl) >= LEVEL_COUNT) begin
      new_lvl = LW'(LEVEL_COUNT - 1);
    end else begin
      new_lvl = LW'(raw_lvl);
    end
  end

  // two-entry command queue
  logic                op_q_r    [2];
  logic [ID_WIDTH-1:0] tid_q_r   [2];
  logic [LW-1:0]       lvl_q_r   [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          fill_r;
  logic                push;

  assign in_stall  = (fill_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd_op    = op_q_r[rd_ptr_r];
  assign cmd_tid   = tid_q_r[rd_ptr_r];
  assign cmd_level = lvl_q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      op_q_r[wr_ptr_r]  <= in_operation;
      tid_q_r[wr_ptr_r] <= in_thread_id;
      lvl_q_r[wr_ptr_r] <= new_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

FILE: design/mlrq_back.sv
// Back end: per-level pointers and counts, the id store and the result register.
`timescale 1ns / 1ps
module mlrq_back #(
  parameter int LEVEL_COUNT = mlrq_pkg::LEVEL_COUNT_DEF,
  parameter int LEVEL_DEPTH = mlrq_pkg::LEVEL_DEPTH_DEF,
  parameter int ID_WIDTH    = mlrq_pkg::ID_WIDTH_DEF,
  localparam int LW         = $clog2(LEVEL_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  logic                          cmd_op,
  input  logic [ID_WIDTH-1:0]           cmd_tid,
  input  logic [LW-1:0]                 cmd_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mlrq_pkg::STATUS_W-1:0] out_status,
  output logic [ID_WIDTH-1:0]           out_chosen_thread,
  output logic [mlrq_pkg::OUT_LVL_W-1:0] out_chosen_level
);
  import mlrq_pkg::*;

  localparam int DW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int AW = LW + DW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state_r, state_nxt;
  logic [DW-1:0] rp_r  [LEVEL_COUNT];
  logic [DW-1:0] wp_r  [LEVEL_COUNT];
  logic [CW-1:0] cnt_r [LEVEL_COUNT];
  logic [LW-1:0] lvl_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [ID_WIDTH-1:0]  thread_r, thread_nxt;
  logic [OUT_LVL_W-1:0] olvl_r, olvl_nxt;

  logic          out_free, go, hit, full, do_wr, do_rd;
  logic [LW-1:0] hit_lvl;
  logic [ID_WIDTH-1:0] rd_data;

  function automatic logic [DW-1:0] ptr_inc(input logic [DW-1:0] p);
    ptr_inc = (p == DW'(LEVEL_DEPTH - 1)) ? '0 : p + DW'(1);
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign go       = (state_r == S_IDLE) && cmd_valid && out_free;
  assign cmd_pop  = go;
  assign full     = (cnt_r[cmd_level] == CW'(LEVEL_DEPTH));
  assign do_wr    = go && (cmd_op == OP_ENQ) && !full;
  assign do_rd    = go && (cmd_op == OP_DEQ) && hit;

  // lowest non-empty level
  always_comb begin
    hit     = 1'b0;
    hit_lvl = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        hit     = 1'b1;
        hit_lvl = LW'(i);
      end
    end
  end

  mlrq_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(1 << AW)
  ) u_id_store (
    .clk    (clk),
    .wr_en  (do_wr),
    .wr_addr({cmd_level, wp_r[cmd_level]}),
    .wr_data(cmd_tid),
    .rd_en  (do_rd),
    .rd_addr({hit_lvl, rp_r[hit_lvl]}),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    thread_nxt    = thread_r;
    olvl_nxt      = olvl_r;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          if (cmd_op == OP_ENQ) begin
            out_valid_nxt = 1'b1;
            status_nxt    = full ? ST_FULL : ST_DONE;
            thread_nxt    = '0;
            olvl_nxt      = OUT_LVL_W'(cmd_level);
          end else if (hit) begin
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_EMPTY;
            thread_nxt    = '0;
            olvl_nxt      = '0;
          end
        end
      end
      S_READ: begin
        // read data holds until the result register is free
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          thread_nxt    = rd_data;
          olvl_nxt      = OUT_LVL_W'(lvl_r);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        rp_r[i]  <= '0;
        wp_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_wr) begin
        wp_r[cmd_level]  <= ptr_inc(wp_r[cmd_level]);
        cnt_r[cmd_level] <= cnt_r[cmd_level] + CW'(1);
      end
      if (do_rd) begin
        rp_r[hit_lvl]  <= ptr_inc(rp_r[hit_lvl]);
        cnt_r[hit_lvl] <= cnt_r[hit_lvl] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    thread_r <= thread_nxt;
    olvl_r   <= olvl_nxt;
    if (do_rd) begin
      lvl_r <= hit_lvl;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_chosen_thread = thread_r;
  assign out_chosen_level  = olvl_r;

endmodule

FILE: design/multilevel_ready_queue_unit.sv
// Top level of the multilevel ready queue: front end, command queue and back end.
// Commands pass through the command queue to the back end, which registers each result.
// Throughput: one enqueue or empty dequeue per cycle while out_stall is low; a dequeue that
// finds an id holds the back end in its read state for the registered read of the id store RAM.
// Reset (rst_n, synchronous, active low) clears pointers, counts, queue and config;
// the id store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module multilevel_ready_queue_unit #(
  parameter int LEVEL_COUNT = mlrq_pkg::LEVEL_COUNT_DEF,
  parameter int LEVEL_DEPTH = mlrq_pkg::LEVEL_DEPTH_DEF,
  parameter int ID_WIDTH    = mlrq_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [ID_WIDTH-1:0]            in_thread_id,
  input  logic [mlrq_pkg::QUANTUM_W-1:0] in_quantum_used,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mlrq_pkg::STATUS_W-1:0]  out_status,
  output logic [ID_WIDTH-1:0]            out_chosen_thread,
  output logic [mlrq_pkg::OUT_LVL_W-1:0] out_chosen_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mlrq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlrq_pkg::QUANTUM_W-1:0] cfg_data
);
  import mlrq_pkg::*;

  localparam int LW = $clog2(LEVEL_COUNT);

  logic                cmd_valid, cmd_pop, cmd_op;
  logic [ID_WIDTH-1:0] cmd_tid;
  logic [LW-1:0]       cmd_level;

  assign cfg_ready = 1'b1;

  mlrq_front #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .ID_WIDTH   (ID_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_thread_id   (in_thread_id),
    .in_quantum_used(in_quantum_used),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd_op         (cmd_op),
    .cmd_tid        (cmd_tid),
    .cmd_level      (cmd_level)
  );

  mlrq_back #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd_pop          (cmd_pop),
    .cmd_op           (cmd_op),
    .cmd_tid          (cmd_tid),
    .cmd_level        (cmd_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_chosen_thread(out_chosen_thread),
    .out_chosen_level (out_chosen_level)
  );

endmodule

FILE: design/mlrq_checker.sv
// Port-level checks for the multilevel ready queue, bound to the top level.
`timescale 1ns / 1ps
module mlrq_checker #(
  parameter int ID_WIDTH = mlrq_pkg::ID_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mlrq_pkg::STATUS_W-1:0]  out_status,
  input logic [ID_WIDTH-1:0]            out_chosen_thread,
  input logic [mlrq_pkg::OUT_LVL_W-1:0] out_chosen_level
);
  import mlrq_pkg::*;

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_chosen_thread) && $stable(out_chosen_level))
    else $error("stalled item changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_EMPTY
      || out_status == ST_FULL))
    else $error("undefined status code");

  a_fail_no_thread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_chosen_thread == '0)
    else $error("thread id on a failed operation");

  a_empty_level0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_chosen_level == '0)
    else $error("non-zero level on empty dequeue");

endmodule

bind multilevel_ready_queue_unit mlrq_checker #(.ID_WIDTH(ID_WIDTH)) u_mlrq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_chosen_thread(out_chosen_thread),
  .out_chosen_level (out_chosen_level)
);

FILE: test/multilevel_ready_queue_unit_test.sv
// Self-checking testbench for the multilevel ready queue unit.
`timescale 1ns / 1ps
module multilevel_ready_queue_unit_test;
  import mlrq_pkg::*;

  localparam int LEVELS        = LEVEL_COUNT_DEF;
  localparam int DEPTH         = LEVEL_DEPTH_DEF;
  localparam int ID_W          = ID_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 215;
  localparam int N_SETTINGS    = 8;
  localparam int N_ROWS        = 11;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      thread;
    logic [OUT_LVL_W-1:0] level;
  } sched_result_t;

  typedef struct packed {
    logic                 op;
    logic [ID_W-1:0]      tid;
    logic [QUANTUM_W-1:0] quantum;
    int unsigned          reps;
    bit                   fixed;
    sched_result_t        result;
  } script_row_t;

  typedef struct packed {
    logic                 mode;
    logic [QUANTUM_W-1:0] one;
    logic [QUANTUM_W-1:0] two;
    logic [QUANTUM_W-1:0] three;
    bit                   calm;
  } limit_set_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [ID_W-1:0]      in_thread_id;
  logic [QUANTUM_W-1:0] in_quantum_used;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]      out_chosen_thread;
  logic [OUT_LVL_W-1:0] out_chosen_level;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [QUANTUM_W-1:0] cfg_data;

  // predicted queue contents and thresholds
  logic [ID_W-1:0]      queued_ids [LEVELS][DEPTH];
  int unsigned          head [LEVELS];
  int unsigned          tail [LEVELS];
  int unsigned          fill [LEVELS];
  logic                 single_mode;
  logic [QUANTUM_W-1:0] lim_one, lim_two, lim_three;

  sched_result_t pending_results [$];

  bit calm;
  bit hold_request;
  int fail_count, n_enq, n_deq, n_refused, n_none, n_checked;

  multilevel_ready_queue_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_thread_id      (in_thread_id),
    .in_quantum_used   (in_quantum_used),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_chosen_thread (out_chosen_thread),
    .out_chosen_level  (out_chosen_level),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  // limits are tried in order, first hit wins, even when out of order
  function automatic int level_for(logic [QUANTUM_W-1:0] q);
    int lv;
    if (q <= lim_one) lv = 0;
    else if (q <= lim_two) lv = 1;
    else if (q <= lim_three) lv = 2;
    else lv = 3;
    if (lv > LEVELS - 1) lv = LEVELS - 1;
    return lv;
  endfunction

  function automatic sched_result_t schedule_op(logic op, logic [ID_W-1:0] tid,
                                                logic [QUANTUM_W-1:0] q);
    sched_result_t r;
    int lv;
    bit found;
    r.status = ST_DONE;
    r.thread = '0;
    r.level  = '0;
    if (op == OP_ENQ) begin
      lv = single_mode ? 0 : level_for(q);
      r.level = lv[OUT_LVL_W-1:0];
      if (fill[lv] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        queued_ids[lv][tail[lv]] = tid;
        tail[lv] = (tail[lv] + 1) % DEPTH;
        fill[lv]++;
      end
    end else begin
      // always scans from level 0 up, whatever the mode
      found = 1'b0;
      for (int i = 0; i < LEVELS && !found; i++) begin
        if (fill[i] != 0) begin
          r.thread = queued_ids[i][head[i]];
          r.level  = i[OUT_LVL_W-1:0];
          head[i]  = (head[i] + 1) % DEPTH;
          fill[i]--;
          found = 1'b1;
        end
      end
      if (!found) r.status = ST_EMPTY;
    end
    return r;
  endfunction

  function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [QUANTUM_W-1:0] d);
    case (idx)
      CFG_SINGLE_MODE: single_mode = d[0];
      CFG_LIMIT_ONE:   lim_one     = d;
      CFG_LIMIT_TWO:   lim_two     = d;
      CFG_LIMIT_THREE: lim_three   = d;
      default: ;
    endcase
  endfunction

  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // partly near the thresholds, partly random or extreme, so every level and both sides of each limit are hit
  function automatic logic [QUANTUM_W-1:0] draw_quantum();
    logic [QUANTUM_W-1:0] pivot;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return QUANTUM_W'($urandom_range(0, 65535));
      4: return '0;
      5: return '1;
      6: pivot = lim_one;
      7: pivot = lim_two;
      default: pivot = lim_three;
    endcase
    return QUANTUM_W'(pivot + $urandom_range(0, 2) - 1);
  endfunction

  function automatic script_row_t row(logic op, logic [ID_W-1:0] tid,
                                      logic [QUANTUM_W-1:0] q, int unsigned reps,
                                      bit fixed, logic [STATUS_W-1:0] st,
                                      logic [OUT_LVL_W-1:0] lv);
    script_row_t r;
    r.op = op;
    r.tid = tid;
    r.quantum = q;
    r.reps = reps;
    r.fixed = fixed;
    r.result.status = st;
    r.result.thread = '0;
    r.result.level = lv;
    return r;
  endfunction

  // directed table, reset thresholds 1/2/4
  function automatic script_row_t script_row(int i);
    case (i)
      0:  return row(OP_DEQ, 8'h00, 16'h0000, 1,  1'b1, ST_EMPTY, 2'd0);
      1:  return row(OP_ENQ, 8'h00, 16'h0000, 1,  1'b1, ST_DONE,  2'd0);
      2:  return row(OP_ENQ, 8'hFF, 16'hFFFF, 1,  1'b1, ST_DONE,  2'd3);
      3:  return row(OP_ENQ, 8'hA5, 16'h0002, 1,  1'b1, ST_DONE,  2'd1);
      4:  return row(OP_ENQ, 8'h5A, 16'h0003, 1,  1'b1, ST_DONE,  2'd2);
      5:  return row(OP_ENQ, 8'h3C, 16'h0004, 1,  1'b1, ST_DONE,  2'd2);
      6:  return row(OP_ENQ, 8'hC3, 16'h0005, 1,  1'b1, ST_DONE,  2'd3);
      7:  return row(OP_ENQ, 8'h01, 16'h0001, 1,  1'b1, ST_DONE,  2'd0);
      8:  return row(OP_ENQ, 8'h77, 16'h8000, 14, 1'b0, ST_DONE,  2'd0);
      9:  return row(OP_ENQ, 8'h88, 16'hFFFF, 1,  1'b1, ST_FULL,  2'd3);
      default: return row(OP_DEQ, 8'h00, 16'h0000, 3, 1'b0, ST_DONE, 2'd0);
    endcase
  endfunction

  function automatic limit_set_t limit_setting(int k);
    limit_set_t s;
    s.mode = 1'b0;
    s.calm = 1'b0;
    case (k)
      0: begin
        s.one = LIMIT_ONE_RST; s.two = LIMIT_TWO_RST; s.three = LIMIT_THREE_RST;
        s.calm = 1'b1;
      end
      1: begin s.one = 16'd100;   s.two = 16'd1000;  s.three = 16'd20000; end
      2: begin s.one = 16'd0;     s.two = 16'd0;     s.three = 16'd0;     end
      3: begin s.one = 16'hFFFF;  s.two = 16'hFFFF;  s.three = 16'hFFFF;  end
      4: begin s.one = 16'd500;   s.two = 16'd100;   s.three = 16'd300;   end
      5: begin
        s.mode = 1'b1; s.one = 16'd7; s.two = 16'd9; s.three = 16'd11;
      end
      6: begin s.one = 16'd0;     s.two = 16'hFFFF;  s.three = 16'd0;     end
      default: begin
        s.one = QUANTUM_W'($urandom_range(0, 65535));
        s.two = QUANTUM_W'($urandom_range(0, 65535));
        s.three = QUANTUM_W'($urandom_range(0, 65535));
      end
    endcase
    return s;
  endfunction

  task automatic offer_item(logic op, logic [ID_W-1:0] tid, logic [QUANTUM_W-1:0] q,
                            bit fixed, sched_result_t typed);
    int gap;
    sched_result_t predicted;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_thread_id    <= tid;
    in_quantum_used <= q;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = schedule_op(op, tid, q);
    pending_results.push_back(fixed ? typed : predicted);
    if (op == OP_ENQ) n_enq++;
    else n_deq++;
  endtask

  // leaves cfg_valid high so back-to-back writes need no lowering in between
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [QUANTUM_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    set_register(idx, d);
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d thread %0d level %0d",
                                  out_status, out_chosen_thread, out_chosen_level));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.status == ST_FULL) n_refused++;
        if (want.status == ST_EMPTY) n_none++;
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
        if (out_chosen_thread !== want.thread)
          report_mismatch($sformatf("chosen_thread got %0d expected %0d",
                                    out_chosen_thread, want.thread));
        if (out_chosen_level !== want.level)
          report_mismatch($sformatf("chosen_level got %0d expected %0d",
                                    out_chosen_level, want.level));
      end
    end
  end

  // result side: random stalls, plus one long hold-off to back the queue up
  initial begin : receiver
    int run;
    out_stall <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        run = calm ? 1 : $urandom_range(1, 12);
        repeat (run) @(posedge clk);
        run = draw_gap();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    script_row_t r;
    limit_set_t s;
    logic op;
    int enq_pct;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= OP_ENQ;
    in_thread_id    <= '0;
    in_quantum_used <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_SINGLE_MODE;
    cfg_data        <= '0;
    calm = 1'b0;
    hold_request = 1'b0;
    fail_count = 0; n_enq = 0; n_deq = 0; n_refused = 0; n_none = 0; n_checked = 0;
    for (int i = 0; i < LEVELS; i++) begin
      head[i] = 0; tail[i] = 0; fill[i] = 0;
    end
    single_mode = 1'b0;
    lim_one = LIMIT_ONE_RST;
    lim_two = LIMIT_TWO_RST;
    lim_three = LIMIT_THREE_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      r = script_row(i);
      repeat (r.reps) offer_item(r.op, r.tid, r.quantum, r.fixed, r.result);
    end
    in_valid <= 1'b0;

    for (int k = 0; k < N_SETTINGS; k++) begin
      settle();
      s = limit_setting(k);
      calm = s.calm;
      write_register(CFG_SINGLE_MODE, {15'd0, s.mode});
      write_register(CFG_LIMIT_ONE, s.one);
      write_register(CFG_LIMIT_TWO, s.two);
      write_register(CFG_LIMIT_THREE, s.three);
      cfg_valid <= 1'b0;
      if (k == 1) hold_request = 1'b1;
      enq_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // bursts lean towards filling or draining so both full and empty show up
        if (n % 30 == 0) begin
          case ($urandom_range(0, 3))
            0: enq_pct = 20;
            1: enq_pct = 50;
            2: enq_pct = 70;
            default: enq_pct = 90;
          endcase
        end
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        offer_item(op, ID_W'($urandom_range(0, 255)), draw_quantum(), 1'b0, '0);
      end
      in_valid <= 1'b0;
    end
    settle();

    $display("Checked %0d results: %0d enqueues (%0d refused as full), %0d dequeues (%0d empty)",
             n_checked, n_enq, n_refused, n_deq, n_none);
    $display("Ran %0d threshold settings incl. extremes, out-of-order limits and single-queue mode",
             N_SETTINGS);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mlrq_pkg.sv
design/mlrq_ram.sv
design/mlrq_front.sv
design/mlrq_back.sv
design/multilevel_ready_queue_unit.sv
design/mlrq_checker.sv
test/multilevel_ready_queue_unit_test.sv
